>>> hdl/nmm_pkg.sv
package nmm_pkg;

  // Default sizes of the block.
  localparam int MAX_DETS_DEF    = 64;
  localparam int NUM_CLASSES_DEF = 80;
  localparam int COORD_BITS_DEF  = 16;

  // Reset values of the configuration registers.
  localparam logic        METRIC_RST    = 1'b1;
  localparam logic [15:0] THRESH_RST    = 16'd32768;
  localparam logic        AGNOSTIC_RST  = 1'b0;

  // Register word indexes (byte address bits 3:2).
  localparam logic [1:0] REG_METRIC   = 2'd0;
  localparam logic [1:0] REG_THRESH   = 2'd1;
  localparam logic [1:0] REG_AGNOSTIC = 2'd2;

  // Status of one stored detection during merging.
  typedef enum logic [1:0] {
    ST_PENDING = 2'd0,
    ST_KEPT    = 2'd1,
    ST_REMOVED = 2'd2
  } status_t;

  // One detection word on the input channel.
  typedef struct packed {
    logic [15:0] box_left;
    logic [15:0] box_top;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic [15:0] confidence;
    logic [6:0]  class_label;
    logic        frame_last;
  } in_word_t;

  // One result word on the output channel.
  typedef struct packed {
    logic [5:0]  det_index;
    logic        removed;
    logic [15:0] out_left;
    logic [15:0] out_top;
    logic [15:0] out_width;
    logic [15:0] out_height;
    logic        overflowed;
    logic        last_result;
  } out_word_t;

endpackage

>>> hdl/nmm_cell.sv
module nmm_cell #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         shift_en,
  input  logic         load_en,
  input  logic [W-1:0] load_d,
  input  logic [W-1:0] shift_d,
  output logic [W-1:0] q
);

  logic [W-1:0] q_r;

  // A loaded detection takes priority; otherwise the slot passes its
  // neighbour's contents along the ring.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (load_en) begin
      q_r <= load_d;
    end else if (shift_en) begin
      q_r <= shift_d;
    end
  end

  assign q = q_r;

endmodule

>>> hdl/nmm_ovl.sv
module nmm_ovl #(
  parameter int CW = 16
) (
  input  logic            clk,
  input  logic            en,
  input  logic            metric,
  input  logic [15:0]     thr,
  input  logic [CW-1:0]   hx1,
  input  logic [CW-1:0]   hy1,
  input  logic [CW-1:0]   hx2,
  input  logic [CW-1:0]   hy2,
  input  logic [CW-1:0]   kx1,
  input  logic [CW-1:0]   ky1,
  input  logic [CW-1:0]   kx2,
  input  logic [CW-1:0]   ky2,
  input  logic [2*CW-1:0] k_area,
  output logic            match,
  output logic [2*CW-1:0] area
);

  logic [CW-1:0]     lx, ty, rx, by, iw, ih, hw, hh;
  logic [2*CW-1:0]   inter1_r, ae1_r, inter2_r, ae2_r, inter3_r, ae3_r, ae4_r;
  logic [2*CW:0]     denom_nxt, denom2_r;
  logic [2*CW+16:0]  prod3_r;
  logic              match4_r;

  // Intersection sides clip at zero.
  always_comb begin
    lx = (hx1 > kx1) ? hx1 : kx1;
    ty = (hy1 > ky1) ? hy1 : ky1;
    rx = (hx2 < kx2) ? hx2 : kx2;
    by = (hy2 < ky2) ? hy2 : ky2;
    iw = (rx > lx) ? (rx - lx) : '0;
    ih = (by > ty) ? (by - ty) : '0;
    hw = hx2 - hx1;
    hh = hy2 - hy1;
  end

  // Denominator: smaller area or union area.
  always_comb begin
    if (metric) begin
      denom_nxt = (2*CW+1)'((ae1_r < k_area) ? ae1_r : k_area);
    end else begin
      denom_nxt = (2*CW+1)'(k_area) + (2*CW+1)'(ae1_r) - (2*CW+1)'(inter1_r);
    end
  end

  // Four stages: areas, denominator, threshold product, compare.
  always_ff @(posedge clk) begin
    if (en) begin
      inter1_r <= (2*CW)'(iw) * (2*CW)'(ih);
      ae1_r    <= (2*CW)'(hw) * (2*CW)'(hh);
      inter2_r <= inter1_r;
      ae2_r    <= ae1_r;
      denom2_r <= denom_nxt;
      inter3_r <= inter2_r;
      ae3_r    <= ae2_r;
      prod3_r  <= (2*CW+17)'(thr) * (2*CW+17)'(denom2_r);
      match4_r <= {1'b0, inter3_r, 16'd0} >= prod3_r;
      ae4_r    <= ae3_r;
    end
  end

  assign match = match4_r;
  assign area  = ae4_r;

endmodule

>>> hdl/box_non_max_merge.sv
// Greedy non-maximum merging of one frame of detections.
//
// Input channel: a detection word is taken at a clock edge where start is
// high and busy is low, one per cycle while the block is idle. Each is
// stored in the next free slot of a ring of MAX_DETS cells; detections past
// that depth are dropped and the frame is flagged as overflowed.
// The word with frame_last set starts merging and raises busy.
// Merging rotates the whole ring through a four-stage overlap unit, one pass
// per kept box plus one final search pass. Then one output pass emits one
// result word per stored detection in arrival order, on consecutive cycles,
// each shown for one cycle with out_strobe. After the output pass busy
// falls and the store is empty again.
// The receiver cannot stall; results are never held back.
// Configuration is written through the APB-style port; the user must
// write it only while idle, as the block itself does not enforce this.
// Reset empties the store, clears the overflow flag and loads the register
// defaults (smaller-area overlap, threshold one half, class-aware).
module box_non_max_merge #(
  parameter int MAX_DETS    = nmm_pkg::MAX_DETS_DEF,
  parameter int NUM_CLASSES = nmm_pkg::NUM_CLASSES_DEF,
  parameter int COORD_BITS  = nmm_pkg::COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  nmm_pkg::in_word_t  in_word,
  output logic               out_strobe,
  output nmm_pkg::out_word_t out_word,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IW  = $clog2(MAX_DETS);
  localparam int CNW = $clog2(MAX_DETS + 1);
  localparam int L   = MAX_DETS + 4;
  localparam int PW  = $clog2(L);
  localparam int LW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int CW  = COORD_BITS;
  localparam int SW  = ((CW > 16) ? CW : 16) + 1;
  localparam logic [SW-1:0] CMAX_S = SW'((1 << CW) - 1);

  typedef struct packed {
    logic             vld;
    logic [IW-1:0]    idx;
    nmm_pkg::status_t st;
    logic [LW-1:0]    lab;
    logic [15:0]      score;
    logic [CW-1:0]    ox1, oy1, ox2, oy2;
    logic [CW-1:0]    mx1, my1, mx2, my2;
  } entry_t;

  typedef struct packed {
    logic [CW-1:0] x1, y1, x2, y2;
  } box_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MERGE = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

  state_t            state_r;
  logic [CNW-1:0]    cnt_r;
  logic              ovf_r;
  logic [PW-1:0]     pass_r;
  logic              metric_r, agn_r;
  logic [15:0]       thr_r;

  logic              have_k_r, kp_vld_r, best_vld_r;
  logic [IW-1:0]     k_idx_r, kp_idx_r, best_idx_r;
  logic [LW-1:0]     k_lab_r, best_lab_r;
  logic [15:0]       best_score_r;
  logic [2*CW-1:0]   k_area_r, best_area_r;
  box_t              k_box_r, acc_r, kp_box_r, best_box_r;

  logic              best_vld_nxt;
  logic [IW-1:0]     best_idx_nxt;
  logic [LW-1:0]     best_lab_nxt;
  logic [15:0]       best_score_nxt;
  logic [2*CW-1:0]   best_area_nxt;
  box_t              best_box_nxt, acc_nxt, out_box;

  entry_t            cell_q [MAX_DETS];
  entry_t            stage_r [4];
  entry_t            load_e, dec, e;
  logic              rotate, accept, full, pass_end;
  logic              match, removed_now, cand;
  logic [2*CW-1:0]   area;
  logic [SW-1:0]     l_ext, t_ext, r_ext, b_ext;
  logic [6:0]        lab_s;
  logic              emit;
  nmm_pkg::out_word_t emit_word, out_word_r;
  logic              out_strobe_r;
  logic              cfg_we;

  assign rotate   = (state_r != S_IDLE);
  assign busy     = rotate;
  assign accept   = start && !busy;
  assign full     = (cnt_r == CNW'(MAX_DETS));
  assign pass_end = (pass_r == PW'(L - 1));

  // Configuration registers.
  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r <= nmm_pkg::METRIC_RST;
      thr_r    <= nmm_pkg::THRESH_RST;
      agn_r    <= nmm_pkg::AGNOSTIC_RST;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        nmm_pkg::REG_METRIC:   metric_r <= pwdata[0];
        nmm_pkg::REG_THRESH:   thr_r    <= pwdata[15:0];
        nmm_pkg::REG_AGNOSTIC: agn_r    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      nmm_pkg::REG_METRIC:   prdata = 32'(metric_r);
      nmm_pkg::REG_THRESH:   prdata = 32'(thr_r);
      nmm_pkg::REG_AGNOSTIC: prdata = 32'(agn_r);
      default:               prdata = '0;
    endcase
  end

  // Incoming detection: saturate edges and class, build the stored entry.
  always_comb begin
    l_ext = SW'(in_word.box_left);
    t_ext = SW'(in_word.box_top);
    r_ext = l_ext + SW'(in_word.box_width);
    b_ext = t_ext + SW'(in_word.box_height);
    lab_s = ({1'b0, in_word.class_label} >= 8'(NUM_CLASSES)) ?
            7'(NUM_CLASSES - 1) : in_word.class_label;
    load_e       = '0;
    load_e.vld   = 1'b1;
    load_e.idx   = cnt_r[IW-1:0];
    load_e.st    = nmm_pkg::ST_PENDING;
    load_e.lab   = lab_s[LW-1:0];
    load_e.score = in_word.confidence;
    load_e.ox1   = (l_ext > CMAX_S) ? CMAX_S[CW-1:0] : l_ext[CW-1:0];
    load_e.oy1   = (t_ext > CMAX_S) ? CMAX_S[CW-1:0] : t_ext[CW-1:0];
    load_e.ox2   = (r_ext > CMAX_S) ? CMAX_S[CW-1:0] : r_ext[CW-1:0];
    load_e.oy2   = (b_ext > CMAX_S) ? CMAX_S[CW-1:0] : b_ext[CW-1:0];
    load_e.mx1   = load_e.ox1;
    load_e.my1   = load_e.oy1;
    load_e.mx2   = load_e.ox2;
    load_e.my2   = load_e.oy2;
  end

  // Ring of detection cells; the last cell takes the decided entry.
  for (genvar i = 0; i < MAX_DETS; i++) begin : g_cell
    entry_t nxt_d;
    assign nxt_d = (i == MAX_DETS - 1) ? dec : cell_q[(i + 1) % MAX_DETS];
    nmm_cell #(.W($bits(entry_t))) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (rotate),
      .load_en  (accept && !full && (cnt_r[IW-1:0] == IW'(i))),
      .load_d   (load_e),
      .shift_d  (nxt_d),
      .q        (cell_q[i])
    );
  end

  // Entries travel alongside the overlap unit's four stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) stage_r[k] <= '0;
    end else if (rotate) begin
      stage_r[0] <= cell_q[0];
      for (int k = 1; k < 4; k++) stage_r[k] <= stage_r[k-1];
    end
  end

  nmm_ovl #(.CW(CW)) u_ovl (
    .clk    (clk),
    .en     (rotate),
    .metric (metric_r),
    .thr    (thr_r),
    .hx1    (cell_q[0].ox1),
    .hy1    (cell_q[0].oy1),
    .hx2    (cell_q[0].ox2),
    .hy2    (cell_q[0].oy2),
    .kx1    (k_box_r.x1),
    .ky1    (k_box_r.y1),
    .kx2    (k_box_r.x2),
    .ky2    (k_box_r.y2),
    .k_area (k_area_r),
    .match  (match),
    .area   (area)
  );

  // Decision on the entry leaving the last stage: removal, union into the
  // keeper, next keeper search, and result words in the output pass.
  always_comb begin
    e              = stage_r[3];
    dec            = e;
    acc_nxt        = acc_r;
    best_vld_nxt   = best_vld_r;
    best_idx_nxt   = best_idx_r;
    best_lab_nxt   = best_lab_r;
    best_score_nxt = best_score_r;
    best_area_nxt  = best_area_r;
    best_box_nxt   = best_box_r;
    removed_now    = 1'b0;
    cand           = 1'b0;
    emit           = 1'b0;
    out_box        = '{e.mx1, e.my1, e.mx2, e.my2};
    if (e.st == nmm_pkg::ST_REMOVED) begin
      out_box = '{e.ox1, e.oy1, e.ox2, e.oy2};
    end else if (kp_vld_r && (e.idx == kp_idx_r)) begin
      out_box = kp_box_r;
    end
    emit_word             = '0;
    emit_word.det_index   = 6'(e.idx);
    emit_word.removed     = (e.st == nmm_pkg::ST_REMOVED);
    emit_word.out_left    = 16'(out_box.x1);
    emit_word.out_top     = 16'(out_box.y1);
    emit_word.out_width   = 16'(out_box.x2 - out_box.x1);
    emit_word.out_height  = 16'(out_box.y2 - out_box.y1);
    emit_word.overflowed  = ovf_r;
    emit_word.last_result = (CNW'(e.idx) == (cnt_r - CNW'(1)));
    if (e.vld && (state_r == S_MERGE)) begin
      if (kp_vld_r && (e.idx == kp_idx_r)) begin
        dec.mx1 = kp_box_r.x1;
        dec.my1 = kp_box_r.y1;
        dec.mx2 = kp_box_r.x2;
        dec.my2 = kp_box_r.y2;
      end
      if (have_k_r && (e.idx == k_idx_r)) begin
        dec.st = nmm_pkg::ST_KEPT;
      end else if ((e.st == nmm_pkg::ST_PENDING) && have_k_r &&
                   (agn_r || (e.lab == k_lab_r)) && match) begin
        removed_now = 1'b1;
        dec.st      = nmm_pkg::ST_REMOVED;
        acc_nxt.x1  = (e.ox1 < acc_r.x1) ? e.ox1 : acc_r.x1;
        acc_nxt.y1  = (e.oy1 < acc_r.y1) ? e.oy1 : acc_r.y1;
        acc_nxt.x2  = (e.ox2 > acc_r.x2) ? e.ox2 : acc_r.x2;
        acc_nxt.y2  = (e.oy2 > acc_r.y2) ? e.oy2 : acc_r.y2;
      end
      cand = (e.st == nmm_pkg::ST_PENDING) && !removed_now &&
             !(have_k_r && (e.idx == k_idx_r));
      // Entries pass in arrival order, so a tie goes to the later one.
      if (cand && (!best_vld_r || (e.score >= best_score_r))) begin
        best_vld_nxt   = 1'b1;
        best_idx_nxt   = e.idx;
        best_lab_nxt   = e.lab;
        best_score_nxt = e.score;
        best_area_nxt  = area;
        best_box_nxt   = '{e.ox1, e.oy1, e.ox2, e.oy2};
      end
    end else if (e.vld && (state_r == S_EMIT)) begin
      emit    = 1'b1;
      dec.vld = 1'b0;
    end
  end

  // Sequencer: load, merge passes, output pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      ovf_r        <= 1'b0;
      pass_r       <= '0;
      have_k_r     <= 1'b0;
      kp_vld_r     <= 1'b0;
      best_vld_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= emit;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (full) begin
              ovf_r <= 1'b1;
            end else begin
              cnt_r <= cnt_r + CNW'(1);
            end
            if (in_word.frame_last) begin
              state_r    <= S_MERGE;
              pass_r     <= '0;
              have_k_r   <= 1'b0;
              kp_vld_r   <= 1'b0;
              best_vld_r <= 1'b0;
            end
          end
        end
        S_MERGE: begin
          pass_r       <= pass_end ? '0 : (pass_r + PW'(1));
          acc_r        <= acc_nxt;
          best_vld_r   <= best_vld_nxt;
          best_idx_r   <= best_idx_nxt;
          best_lab_r   <= best_lab_nxt;
          best_score_r <= best_score_nxt;
          best_area_r  <= best_area_nxt;
          best_box_r   <= best_box_nxt;
          if (pass_end) begin
            kp_vld_r   <= have_k_r;
            kp_idx_r   <= k_idx_r;
            kp_box_r   <= acc_nxt;
            best_vld_r <= 1'b0;
            have_k_r   <= best_vld_nxt;
            k_idx_r    <= best_idx_nxt;
            k_lab_r    <= best_lab_nxt;
            k_area_r   <= best_area_nxt;
            k_box_r    <= best_box_nxt;
            acc_r      <= best_box_nxt;
            if (!best_vld_nxt) begin
              state_r <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          pass_r <= pass_end ? '0 : (pass_r + PW'(1));
          if (pass_end) begin
            state_r  <= S_IDLE;
            cnt_r    <= '0;
            ovf_r    <= 1'b0;
            kp_vld_r <= 1'b0;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_word_r <= emit_word;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

`ifndef NO_ASSERTIONS
  // Result words only come out of the output pass.
  a_strobe_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == S_EMIT))
    else $error("result word outside the output pass");

  // While idle the overlap stages carry no detection.
  a_idle_stages: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!stage_r[3].vld && !stage_r[0].vld))
    else $error("detection in overlap stages while idle");

  // The fill count never passes the store depth.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNW'(MAX_DETS))
    else $error("fill count beyond store depth");

  // A keeper is only ever held while merging.
  a_keeper_merge: assert property (@(posedge clk) disable iff (!rst_n)
    have_k_r |-> (state_r == S_MERGE))
    else $error("keeper held outside merging");
`endif

endmodule
